// ===== src/sts_pkg.sv =====
`default_nettype none
package sts_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned INDEX_W = 10;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

endpackage
`default_nettype wire

// ===== src/sts_in_if.sv =====
`default_nettype none
interface sts_in_if;
	logic valid;
	logic ready;
	logic [sts_pkg::KIND_W-1:0] kind;
	logic signed [sts_pkg::VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ===== src/sts_out_if.sv =====
`default_nettype none
interface sts_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [sts_pkg::INDEX_W-1:0] first_index;
	logic [sts_pkg::INDEX_W-1:0] last_index;

	modport source (output valid, output found, output first_index, output last_index,
		input ready);
	modport sink (input valid, input found, input first_index, input last_index,
		output ready);
endinterface
`default_nettype wire

// ===== src/sorted_table_equal_range_search.sv =====
// Sorted-table equal-range search. Each word on req carries a kind and a value: clear empties
// the table, append adds the value at the end (ignored when DEPTH entries are held) and search
// returns one word on rsp with a found flag and the first and last index of the key, both zero
// when the key is absent or the table is empty; kind 3 is dropped. A two-entry queue sits between
// the input and the table engine, and the result register lets the next word be taken while a
// result waits. Clear and append are done straight from the engine's idle state. A search runs a
// lower-bound and then an upper-bound bisection over the filled entries; each probe has a read
// state and a compare state because the table memory has a registered read port.
`default_nettype none
module sorted_table_equal_range_search #(
	parameter int unsigned DEPTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	sts_in_if.sink req,
	sts_out_if.source rsp
);

	logic cmd_valid;
	logic cmd_pop;
	sts_pkg::cmd_t cmd;

	sts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	sts_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

// ===== src/sts_front.sv =====
`default_nettype none
module sts_front (
	input wire logic clk,
	input wire logic arst_n,
	sts_in_if.sink req,
	output logic cmd_valid,
	output sts_pkg::cmd_t cmd,
	input wire logic cmd_pop
);

	sts_pkg::cmd_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;
	logic kind_ok;
	sts_pkg::cmd_t new_cmd;

	always_comb begin
		kind_ok = 1'b1;
		new_cmd.value = req.value;
		case (req.kind)
			sts_pkg::KIND_CLEAR: new_cmd.op = sts_pkg::OP_CLEAR;
			sts_pkg::KIND_APPEND: new_cmd.op = sts_pkg::OP_APPEND;
			sts_pkg::KIND_SEARCH: new_cmd.op = sts_pkg::OP_SEARCH;
			default: begin
				new_cmd.op = sts_pkg::OP_CLEAR;
				kind_ok = 1'b0;
			end
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready && kind_ok;
	assign pop = cmd_pop && (cnt_q != 2'd0);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/sts_back.sv =====
`default_nettype none
module sts_back #(
	parameter int unsigned DEPTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire sts_pkg::cmd_t cmd,
	output logic cmd_pop,
	sts_out_if.source rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LB_RD = 8'b0000_0010,
		S_LB_CMP = 8'b0000_0100,
		S_CHK = 8'b0000_1000,
		S_UB_RD = 8'b0001_0000,
		S_UB_CMP = 8'b0010_0000,
		S_RESULT = 8'b0100_0000,
		S_WAIT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic signed [sts_pkg::VALUE_W-1:0] mem [DEPTH];
	logic signed [sts_pkg::VALUE_W-1:0] rdata_q;
	logic signed [sts_pkg::VALUE_W-1:0] key_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid;
	logic [CW-1:0] mid_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic in_range;
	logic res_found_q;
	logic [AW+sts_pkg::INDEX_W-1:0] first_ext;
	logic [AW+sts_pkg::INDEX_W-1:0] last_ext;
	logic rsp_valid_q;
	logic rsp_found_q;
	logic [sts_pkg::INDEX_W-1:0] rsp_first_q;
	logic [sts_pkg::INDEX_W-1:0] rsp_last_q;
	logic rsp_free;

	assign in_range = (lo_q < hi_q);
	assign mid = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);
	assign rd_addr = (in_range && (state_q == S_LB_RD || state_q == S_UB_RD))
		? mid[AW-1:0] : pos_q;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign mem_we = cmd_pop && (cmd.op == sts_pkg::OP_APPEND) && (count_q < DEPTH_C);
	assign first_ext = {{sts_pkg::INDEX_W{1'b0}}, first_q};
	assign last_ext = {{sts_pkg::INDEX_W{1'b0}}, pos_q};
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.found = rsp_found_q;
	assign rsp.first_index = rsp_first_q;
	assign rsp.last_index = rsp_last_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= cmd.value;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && rsp_free) begin
			rsp_found_q <= res_found_q;
			rsp_first_q <= res_found_q ? first_ext[sts_pkg::INDEX_W-1:0] : '0;
			rsp_last_q <= res_found_q ? last_ext[sts_pkg::INDEX_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			pos_q <= '0;
			first_q <= '0;
			key_q <= '0;
			res_found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							sts_pkg::OP_CLEAR: count_q <= '0;
							sts_pkg::OP_APPEND: begin
								if (count_q < DEPTH_C) begin
									count_q <= count_q + CW'(1);
								end
							end
							sts_pkg::OP_SEARCH: begin
								key_q <= cmd.value;
								lo_q <= '0;
								hi_q <= count_q;
								pos_q <= '0;
								first_q <= '0;
								res_found_q <= 1'b0;
								state_q <= (count_q == '0) ? S_RESULT : S_LB_RD;
							end
							default: count_q <= count_q;
						endcase
					end
				end
				S_LB_RD: begin
					mid_q <= mid;
					state_q <= in_range ? S_LB_CMP : S_CHK;
				end
				S_LB_CMP: begin
					if (rdata_q >= key_q) begin
						pos_q <= mid_q[AW-1:0];
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + CW'(1);
					end
					state_q <= S_LB_RD;
				end
				S_CHK: begin
					if (rdata_q != key_q) begin
						state_q <= S_RESULT;
					end else begin
						first_q <= pos_q;
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_UB_RD;
					end
				end
				S_UB_RD: begin
					mid_q <= mid;
					if (in_range) begin
						state_q <= S_UB_CMP;
					end else begin
						res_found_q <= 1'b1;
						state_q <= S_RESULT;
					end
				end
				S_UB_CMP: begin
					if (rdata_q <= key_q) begin
						pos_q <= mid_q[AW-1:0];
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_UB_RD;
				end
				S_RESULT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sim/sts_checker.sv =====
`timescale 1ns / 100ps
module sts_checker
	import sts_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	sts_in_if req,
	sts_out_if rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic found;
		logic [INDEX_W-1:0] first_index;
		logic [INDEX_W-1:0] last_index;
	} range_t;

	logic signed [VALUE_W-1:0] stored [DEPTH];
	int unsigned held;
	range_t pending_ranges [$];
	int unsigned fail_count;

	// The probe order must match the block even when the table is out of order.
	function automatic range_t equal_range(input logic signed [VALUE_W-1:0] key);
		int lo;
		int hi;
		int mid;
		int pos;
		int first_pos;
		range_t r;
		r = '0;
		if (held == 0) begin
			return r;
		end
		lo = 0;
		hi = int'(held) - 1;
		pos = 0;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored[mid] >= key) begin
				pos = mid;
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		if (stored[pos] != key) begin
			return r;
		end
		first_pos = pos;
		lo = 0;
		hi = int'(held) - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored[mid] <= key) begin
				pos = mid;
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		r.found = 1'b1;
		r.first_index = first_pos[INDEX_W-1:0];
		r.last_index = pos[INDEX_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		range_t want;
		if (!arst_n) begin
			held = 0;
			pending_ranges.delete();
			fail_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				case (req.kind)
					KIND_CLEAR: begin
						held = 0;
					end
					KIND_APPEND: begin
						if (held < DEPTH) begin
							stored[held] = req.value;
							held++;
						end
					end
					KIND_SEARCH: begin
						pending_ranges.push_back(equal_range(req.value));
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_ranges.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word, expected none, actual found %0b first %0d last %0d",
						$time, rsp.found, rsp.first_index, rsp.last_index);
				end else begin
					want = pending_ranges.pop_front();
					check_field("found", want.found, rsp.found);
					check_field("first_index", want.first_index, rsp.first_index);
					check_field("last_index", want.last_index, rsp.last_index);
				end
			end
			mismatches <= fail_count;
			outstanding <= pending_ranges.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import sts_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned RANDOM_WORDS = 60;
	localparam int unsigned RSP_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic press_rsp;
	bit quiet;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned words_sent;
	logic signed [VALUE_W-1:0] loaded [$];

	sts_in_if req_if ();
	sts_out_if rsp_if ();

	sorted_table_equal_range_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	sts_checker #(
		.DEPTH(DEPTH)
	) range_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_key();
		int unsigned r;
		logic signed [VALUE_W-1:0] k;
		r = $urandom_range(0, 99);
		if (loaded.size() == 0 || r >= 85) begin
			return $urandom;
		end
		k = loaded[$urandom_range(0, loaded.size() - 1)];
		if (r < 15) begin
			k = k + 1;
		end else if (r < 25) begin
			k = k - 1;
		end
		return k;
	endfunction

	task automatic put_word(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value);
		int unsigned gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.kind <= kind;
		req_if.value <= value;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (kind != KIND_UNUSED) begin
			words_sent++;
		end
		if (kind == KIND_CLEAR) begin
			loaded.delete();
		end else if (kind == KIND_APPEND) begin
			loaded.push_back(value);
		end
	endtask

	// Ascending run with a random start and random steps, duplicates included.
	task automatic load_ascending(input int unsigned count);
		logic signed [VALUE_W-1:0] s;
		longint v;
		int unsigned step;
		int unsigned r;
		r = $urandom_range(0, 2);
		step = (r == 0) ? 2 : (r == 1) ? 1000 : (1 << 24);
		s = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			s = 32'sh8000_0000;
		end
		v = longint'(s);
		repeat (count) begin
			put_word(KIND_APPEND, v[VALUE_W-1:0]);
			v = v + longint'($urandom_range(0, step));
			if (v > 64'sd2147483647) begin
				v = 64'sd2147483647;
			end
		end
	endtask

	function automatic int unsigned table_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 12);
		end
		if (r < 95) begin
			return $urandom_range(13, 80);
		end
		return $urandom_range(81, 300);
	endfunction

	initial begin
		int unsigned span;
		bit held_once;
		held_once = 0;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (press_rsp && !held_once) begin
				held_once = 1;
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD) @(posedge clk);
			end else begin
				span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(100, 300);
				rsp_if.ready <= 1'b1;
				repeat (span) @(posedge clk);
				span = gap_len();
				if (span > 0) begin
					rsp_if.ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int unsigned base;
		int unsigned r;
		int unsigned i;
		arst_n = 1'b0;
		press_rsp = 1'b0;
		quiet = 0;
		words_sent = 0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_CLEAR;
		req_if.value = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		put_word(KIND_SEARCH, 32'sd0);
		put_word(KIND_APPEND, 32'sh8000_0000);
		put_word(KIND_APPEND, -32'sd5);
		put_word(KIND_APPEND, -32'sd5);
		put_word(KIND_APPEND, -32'sd5);
		put_word(KIND_APPEND, 32'sd0);
		put_word(KIND_APPEND, 32'sd7);
		put_word(KIND_APPEND, 32'sh7fff_ffff);
		put_word(KIND_SEARCH, 32'sh8000_0000);
		put_word(KIND_SEARCH, -32'sd5);
		put_word(KIND_SEARCH, 32'sh7fff_ffff);
		put_word(KIND_SEARCH, 32'sd3);
		put_word(KIND_SEARCH, 32'sh8000_0001);
		put_word(KIND_SEARCH, 32'sd0);
		put_word(KIND_UNUSED, -32'sd1);
		put_word(KIND_SEARCH, 32'sd7);
		put_word(KIND_CLEAR, 32'sh7fff_ffff);
		put_word(KIND_SEARCH, -32'sd5);
		put_word(KIND_APPEND, 32'sd42);
		put_word(KIND_SEARCH, 32'sd42);
		put_word(KIND_SEARCH, 32'sd41);
		put_word(KIND_APPEND, 32'sd3);
		put_word(KIND_SEARCH, 32'sd3);
		put_word(KIND_SEARCH, 32'sd42);

		// Fill past the end; the surplus words must be dropped.
		put_word(KIND_CLEAR, 32'sd0);
		for (i = 0; i < DEPTH + 6; i++) begin
			put_word(KIND_APPEND, (i < DEPTH) ? int'(i / 4) * 3 - 1500 : 32'sd999999);
		end
		press_rsp <= 1'b1;
		quiet = 1;
		put_word(KIND_SEARCH, -32'sd1500);
		put_word(KIND_SEARCH, -32'sd735);
		put_word(KIND_SEARCH, 32'sd999999);
		put_word(KIND_SEARCH, -32'sd1501);
		put_word(KIND_SEARCH, -32'sd734);
		repeat (40) begin
			i = $urandom_range(0, DEPTH - 1);
			put_word(KIND_SEARCH, int'(i / 4) * 3 - 1500 + $urandom_range(0, 1));
		end

		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if ($urandom_range(0, 6) != 0) begin
					put_word(KIND_CLEAR, $urandom);
				end
				load_ascending(table_size());
				repeat ($urandom_range(1, 8)) put_word(KIND_SEARCH, pick_key());
			end else if (r < 87) begin
				put_word(KIND_CLEAR, $urandom);
				repeat ($urandom_range(1, 20)) put_word(KIND_APPEND, $urandom);
				repeat ($urandom_range(1, 6)) put_word(KIND_SEARCH, pick_key());
			end else begin
				repeat ($urandom_range(3, 10)) put_word(KIND_W'($urandom_range(0, 3)), pick_key());
			end
		end

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
